// ----- design/mhcv_pkg.sv -----
`timescale 1ns / 1ps

package mhcv_pkg;

  // Header layout and framing.
  localparam int unsigned HdrLen  = 36;
  localparam int unsigned PosW    = 6;
  localparam int unsigned RecLen  = 24;

  // Field widths of the configuration registers.
  localparam int unsigned IdxCrcW  = 32;
  localparam int unsigned MaxRecW  = 21;
  localparam int unsigned MaxPoolW = 26;

  // Payload length: record count times 24 plus pool size, both already
  // bounded by the limit registers when the length is used.
  localparam int unsigned RemW = 27;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcOnes = 32'hFFFF_FFFF;

  localparam logic [IdxCrcW-1:0]  IdxCrcRst  = '0;
  localparam logic [MaxRecW-1:0]  MaxRecRst  = 21'd100000;
  localparam logic [MaxPoolW-1:0] MaxPoolRst = 26'd33554432;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_HEADER,
    ST_SHORT,
    ST_MISMATCH
  } status_e;

  typedef enum logic [1:0] {
    CFG_INDEX_CRC,
    CFG_MAX_RECORDS,
    CFG_MAX_POOL
  } cfg_index_e;

  // Item operation codes.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOF  = 1'b1;

  // Decoded meaning of one header byte.
  typedef struct packed {
    logic       bad;      // byte violates a fixed field
    logic       rec_we;   // byte belongs to the record count
    logic       pool_we;  // byte belongs to the pool size
    logic       crc_we;   // byte belongs to the stored payload CRC
    logic [1:0] lane;     // byte lane within the 32-bit field
  } hdr_dec_t;

  // One byte of reflected CRC-32, eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  // Magic tag "FPMNF01", one character per header position.
  function automatic logic [7:0] magic_byte(input logic [2:0] p);
    logic [7:0] m;
    unique case (p)
      3'd0:    m = 8'h46;
      3'd1:    m = 8'h50;
      3'd2:    m = 8'h4D;
      3'd3:    m = 8'h4E;
      3'd4:    m = 8'h46;
      3'd5:    m = 8'h30;
      3'd6:    m = 8'h31;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// ----- design/mhcv_if.sv -----
`timescale 1ns / 1ps

// Input channel: one file byte or an end-of-file item.
interface mhcv_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

// Result channel: one verdict per file.
interface mhcv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] computed_crc;

  modport source (output valid, output status, output computed_crc, input ready);
  modport sink   (input valid, input status, input computed_crc, output ready);
endinterface

// Configuration write channel.
interface mhcv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/mhcv_hdr_check.sv -----
`timescale 1ns / 1ps

module mhcv_hdr_check (
  input  logic [mhcv_pkg::PosW-1:0]    pos_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [mhcv_pkg::IdxCrcW-1:0] index_crc_i,
  output mhcv_pkg::hdr_dec_t           dec_o
);
  import mhcv_pkg::*;

  logic [7:0] want;

  // Decode the header position and check the fixed fields.
  always_comb begin
    dec_o      = '0;
    dec_o.lane = pos_i[1:0];
    want       = 8'd0;
    if (pos_i < 6'd7) begin
      dec_o.bad = (data_byte_i != magic_byte(pos_i[2:0]));
    end else if (pos_i >= 6'd8 && pos_i <= 6'd13) begin
      if (pos_i[0]) begin
        want = 8'd0;
      end else if (pos_i == 6'd8) begin
        want = 8'd1;
      end else if (pos_i == 6'd10) begin
        want = 8'(HdrLen);
      end else begin
        want = 8'(RecLen);
      end
      dec_o.bad = (data_byte_i != want);
    end else if (pos_i >= 6'd16 && pos_i <= 6'd19) begin
      dec_o.rec_we = 1'b1;
    end else if (pos_i >= 6'd20 && pos_i <= 6'd23) begin
      dec_o.pool_we = 1'b1;
    end else if (pos_i >= 6'd24 && pos_i <= 6'd27) begin
      dec_o.crc_we = 1'b1;
    end else if (pos_i >= 6'd28 && pos_i <= 6'd31) begin
      dec_o.bad = (data_byte_i != index_crc_i[8*pos_i[1:0] +: 8]);
    end else if (pos_i >= 6'd32 && pos_i <= 6'd35) begin
      want      = (pos_i == 6'd32) ? 8'd1 : 8'd0;
      dec_o.bad = (data_byte_i != want);
    end
  end

endmodule

// ----- design/manifest_header_crc_validator.sv -----
`timescale 1ns / 1ps

// Manifest header and payload CRC validator.
// A file enters on in_i as one item per byte (op 0), closed by an
// end-of-file item (op 1). The 36-byte header is checked as it streams
// by; after a good header a reflected CRC-32 runs over the payload, whose
// length is record count times 24 plus pool size, and is compared with the
// CRC stored in the header. One verdict item leaves on out_o per file:
// ok, bad header, short file or CRC mismatch. Bytes after the verdict are
// dropped; end of file always rearms the block for the next file.
// Throughput is one item per cycle: each byte passes through one CRC byte
// step and the header compare, between the state registers and the result
// register. A verdict appears on out_o in the cycle after the deciding item.
// The result register is the only buffer: while a verdict waits on a
// stalled receiver, in_i.ready is low and every input item waits, whether
// or not it would produce a verdict; in_i.ready follows out_o.ready in the
// same cycle, so a verdict taken frees the input at once.
// Reset empties the result register, loads the limit registers with their
// defaults and puts the block at the start of a header. Configuration
// writes on cfg_i are always ready and take effect the next cycle.
module manifest_header_crc_validator (
  input  logic clk_i,
  input  logic rst_ni,
  mhcv_in_if.sink    in_i,
  mhcv_out_if.source out_o,
  mhcv_cfg_if.sink   cfg_i
);
  import mhcv_pkg::*;

  // Configuration registers.
  logic [IdxCrcW-1:0]  index_crc_q;
  logic [MaxRecW-1:0]  max_rec_q;
  logic [MaxPoolW-1:0] max_pool_q;

  // Per-file state.
  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q;
  logic            hdr_bad_q;
  logic [31:0]     rec_total_q;
  logic [31:0]     pool_total_q;
  logic [31:0]     stored_crc_q;
  logic [RemW-1:0] rem_q;
  logic [31:0]     crc_q;

  // Result register.
  logic        out_valid_q;
  logic [1:0]  status_q;
  logic [31:0] res_crc_q;

  logic        in_fire;
  logic        is_byte;
  logic        is_eof;
  hdr_dec_t    dec;
  logic        hdr_last;
  logic        limit_bad;
  logic        hdr_fail;
  logic [RemW-1:0] rem_calc;
  logic [31:0] crc_next;
  logic        pay_last;
  logic        emit;
  status_e     emit_status;
  logic [31:0] emit_crc;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign is_byte     = in_fire && (in_i.op == OP_BYTE);
  assign is_eof      = in_fire && (in_i.op == OP_EOF);
  assign cfg_i.ready = 1'b1;

  mhcv_hdr_check u_hdr_check (
    .pos_i       (pos_q),
    .data_byte_i (in_i.data_byte),
    .index_crc_i (index_crc_q),
    .dec_o       (dec)
  );

  // Header close-out: limits, total verdict and payload length.
  assign hdr_last  = (pos_q == PosW'(HdrLen - 1));
  assign limit_bad = (rec_total_q > {11'd0, max_rec_q}) ||
                     (pool_total_q > {6'd0, max_pool_q});
  assign hdr_fail  = hdr_bad_q || dec.bad || limit_bad;
  assign rem_calc  = {2'd0, rec_total_q[MaxRecW-1:0], 4'd0} +
                     {3'd0, rec_total_q[MaxRecW-1:0], 3'd0} +
                     {1'b0, pool_total_q[MaxPoolW-1:0]};

  // Payload CRC step.
  assign crc_next = crc_byte(crc_q, in_i.data_byte);
  assign pay_last = (rem_q == RemW'(1));

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (is_eof) begin
      phase_d = PH_HEADER;
    end else if (is_byte) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_last) begin
            phase_d = (hdr_fail || rem_calc == '0) ? PH_DONE : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_d = PH_DONE;
          end
        end
        PH_DONE:  phase_d = PH_DONE;
        default:  phase_d = PH_HEADER;
      endcase
    end
  end

  // Verdict for the current item, if it decides one.
  always_comb begin
    emit        = 1'b0;
    emit_status = ST_OK;
    emit_crc    = '0;
    if (is_eof) begin
      unique case (phase_q)
        PH_HEADER: begin
          emit        = 1'b1;
          emit_status = ST_BAD_HEADER;
        end
        PH_PAYLOAD: begin
          emit        = 1'b1;
          emit_status = ST_SHORT;
          emit_crc    = ~crc_q;
        end
        PH_DONE:  emit = 1'b0;
        default:  emit = 1'b0;
      endcase
    end else if (is_byte) begin
      unique case (phase_q)
        PH_HEADER: begin
          if (hdr_last) begin
            if (hdr_fail) begin
              emit        = 1'b1;
              emit_status = ST_BAD_HEADER;
            end else if (rem_calc == '0) begin
              emit        = 1'b1;
              emit_status = (stored_crc_q == 32'd0) ? ST_OK : ST_MISMATCH;
            end
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            emit        = 1'b1;
            emit_crc    = ~crc_next;
            emit_status = (~crc_next == stored_crc_q) ? ST_OK : ST_MISMATCH;
          end
        end
        PH_DONE:  emit = 1'b0;
        default:  emit = 1'b0;
      endcase
    end
  end

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      index_crc_q <= IdxCrcRst;
      max_rec_q   <= MaxRecRst;
      max_pool_q  <= MaxPoolRst;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == CFG_INDEX_CRC) begin
        index_crc_q <= cfg_i.data;
      end else if (cfg_i.index == CFG_MAX_RECORDS) begin
        max_rec_q <= cfg_i.data[MaxRecW-1:0];
      end else if (cfg_i.index == CFG_MAX_POOL) begin
        max_pool_q <= cfg_i.data[MaxPoolW-1:0];
      end
    end
  end

  // Per-file state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      pos_q        <= '0;
      hdr_bad_q    <= 1'b0;
      rec_total_q  <= '0;
      pool_total_q <= '0;
      stored_crc_q <= '0;
      rem_q        <= '0;
      crc_q        <= CrcOnes;
    end else begin
      phase_q <= phase_d;
      if (is_eof) begin
        pos_q        <= '0;
        hdr_bad_q    <= 1'b0;
        rec_total_q  <= '0;
        pool_total_q <= '0;
        stored_crc_q <= '0;
        rem_q        <= '0;
        crc_q        <= CrcOnes;
      end else if (is_byte && phase_q == PH_HEADER) begin
        pos_q <= pos_q + PosW'(1);
        // A fixed-field violation, or a limit failure on the last byte.
        if (dec.bad || (hdr_last && limit_bad)) begin
          hdr_bad_q <= 1'b1;
        end
        if (dec.rec_we) begin
          rec_total_q[8*dec.lane +: 8] <= in_i.data_byte;
        end
        if (dec.pool_we) begin
          pool_total_q[8*dec.lane +: 8] <= in_i.data_byte;
        end
        if (dec.crc_we) begin
          stored_crc_q[8*dec.lane +: 8] <= in_i.data_byte;
        end
        if (hdr_last) begin
          rem_q <= rem_calc;
          crc_q <= CrcOnes;
        end
      end else if (is_byte && phase_q == PH_PAYLOAD) begin
        crc_q <= crc_next;
        rem_q <= rem_q - RemW'(1);
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      status_q  <= emit_status;
      res_crc_q <= emit_crc;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = status_q;
  assign out_o.computed_crc = res_crc_q;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import mhcv_pkg::*;

  localparam int NA = -1;
  localparam int RandItems = 200;
  localparam int SettleCycles = 8;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 3000;
  localparam logic [55:0] MagicTag = "FPMNF01";

  typedef struct packed {
    status_e     status;
    logic [31:0] crc;
  } verdict_t;

  // One file of stimulus. A negative position or length means unused.
  typedef struct packed {
    logic [31:0] rec;
    logic [31:0] pool;
    bit          crc_good;
    int          bad_pos;
    logic [7:0]  bad_xor;
    int          cut;
    int          trail;
    bit          eof;
    int          pause_at;
    logic [31:0] p_idx;
    logic [20:0] p_rec;
    logic [25:0] p_pool;
    bit          chk;
    status_e     st;
    logic [31:0] crc;
  } file_case_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mhcv_in_if  in_if ();
  mhcv_out_if out_if ();
  mhcv_cfg_if cfg_if ();

  manifest_header_crc_validator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk_i = ~clk_i;

  // Directed files. Typed verdicts only where they are plain to see.
  file_case_t dir_cases [26] = '{
    '{0, 0, 1, NA, 8'h00, 0, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, NA, 8'h00, NA, 0, 1, NA, 0, 0, 0, 1, ST_OK, 0},
    '{1, 3, 1, NA, 8'h00, NA, 0, 1, 0, 32'hFFFF_FFFF, 21'd1048576, 26'd33554432,
      0, ST_OK, 0},
    '{0, 5, 0, NA, 8'h00, NA, 0, 1, NA, 0, 0, 0, 0, ST_OK, 0},
    '{0, 0, 1, 0, 8'h01, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 6, 8'h80, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 8, 8'h02, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 9, 8'h80, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 10, 8'h01, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 12, 8'h10, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 31, 8'h80, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 32, 8'h01, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 0, 1, 35, 8'h40, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{1, 0, 1, 14, 8'hFF, NA, 0, 1, NA, 0, 0, 0, 0, ST_OK, 0},
    '{32'hFFFF_FFFF, 0, 1, NA, 8'h00, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 32'd33554433, 1, NA, 8'h00, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{32'd1048576, 32'd33554432, 1, NA, 8'h00, 46, 0, 1, NA, 0, 0, 0, 0, ST_OK, 0},
    '{0, 0, 1, NA, 8'h00, 20, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{0, 4, 1, NA, 8'h00, NA, 5, 1, NA, 0, 0, 0, 0, ST_OK, 0},
    '{0, 0, 1, NA, 8'h00, NA, 0, 1, 0, 0, 0, 0, 1, ST_OK, 0},
    '{1, 0, 1, NA, 8'h00, NA, 0, 1, NA, 0, 0, 0, 1, ST_BAD_HEADER, 0},
    '{2, 7, 1, NA, 8'h00, NA, 0, 1, 30, 32'h0000_A5A5, 2, 7, 0, ST_OK, 0},
    '{0, 0, 1, NA, 8'h00, NA, 0, 1, 30, 32'h1234_0000, 2, 7, 1, ST_BAD_HEADER, 0},
    '{2, 0, 1, NA, 8'h00, NA, 0, 1, 35, 32'h1234_0000, 1, 7, 1, ST_BAD_HEADER, 0},
    '{0, 1, 1, NA, 8'h00, NA, 0, 0, NA, 0, 0, 0, 0, ST_OK, 0},
    '{0, 2, 1, NA, 8'h00, NA, 0, 1, NA, 0, 0, 0, 0, ST_OK, 0}
  };

  // Register values as the block holds them, updated on each accepted write.
  logic [31:0] lim_idx_crc  = IdxCrcRst;
  logic [20:0] lim_max_rec  = MaxRecRst;
  logic [25:0] lim_max_pool = MaxPoolRst;

  // Register values last programmed, used to build file headers.
  logic [31:0] set_idx_crc  = IdxCrcRst;
  logic [20:0] set_max_rec  = MaxRecRst;
  logic [25:0] set_max_pool = MaxPoolRst;

  // Per-file state of the verdict predictor.
  phase_e          file_phase;
  logic [PosW-1:0] hdr_pos;
  bit              hdr_bad;
  logic [31:0]     hdr_records;
  logic [31:0]     hdr_pool;
  logic [31:0]     hdr_crc;
  logic [33:0]     payload_left;
  logic [31:0]     run_crc;
  bit              verdict_out;

  verdict_t pending_verdicts[$];
  verdict_t last_verdict;
  int       items_taken = 0;
  int       verdicts_seen = 0;
  int       errors = 0;
  int       idle_cycles = 0;
  int       hold_len = 0;
  bit       calm = 1'b0;

  function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void open_file();
    file_phase   = PH_HEADER;
    hdr_pos      = '0;
    hdr_bad      = 1'b0;
    hdr_records  = '0;
    hdr_pool     = '0;
    hdr_crc      = '0;
    payload_left = '0;
    run_crc      = CrcOnes;
    verdict_out  = 1'b0;
  endfunction

  // Advance the predictor by one accepted item; returns 1 when a verdict is due.
  function automatic bit judge_item(input logic op, input logic [7:0] b,
                                    output verdict_t v);
    bit          emit;
    bit          finish;
    int unsigned p;
    logic [7:0]  want;
    emit   = 1'b0;
    finish = 1'b0;
    v.status = ST_OK;
    v.crc    = '0;
    if (op == OP_EOF) begin
      if (!verdict_out && file_phase == PH_HEADER) begin
        v.status = ST_BAD_HEADER;
        emit = 1'b1;
      end else if (!verdict_out && file_phase == PH_PAYLOAD) begin
        v.status = ST_SHORT;
        v.crc    = run_crc ^ CrcOnes;
        emit = 1'b1;
      end
      open_file();
      return emit;
    end
    if (file_phase == PH_HEADER) begin
      p = hdr_pos;
      if (p < 7) begin
        hdr_bad |= (b != MagicTag[8*(6-p) +: 8]);
      end else if (p >= 8 && p <= 13) begin
        if (p % 2 == 1) want = 8'd0;
        else if (p == 8) want = 8'd1;
        else if (p == 10) want = 8'(HdrLen);
        else want = 8'(RecLen);
        hdr_bad |= (b != want);
      end else if (p >= 16 && p <= 19) begin
        hdr_records[8*(p-16) +: 8] = b;
      end else if (p >= 20 && p <= 23) begin
        hdr_pool[8*(p-20) +: 8] = b;
      end else if (p >= 24 && p <= 27) begin
        hdr_crc[8*(p-24) +: 8] = b;
      end else if (p >= 28 && p <= 31) begin
        hdr_bad |= (b != lim_idx_crc[8*(p-28) +: 8]);
      end else if (p >= 32) begin
        hdr_bad |= (b != ((p == 32) ? 8'd1 : 8'd0));
      end
      hdr_pos = hdr_pos + 1'b1;
      if (hdr_pos >= HdrLen) begin
        if (hdr_records > lim_max_rec || hdr_pool > lim_max_pool) hdr_bad = 1'b1;
        if (hdr_bad) begin
          v.status = ST_BAD_HEADER;
          emit = 1'b1;
        end else begin
          payload_left = 34'(hdr_records) * 34'(RecLen) + 34'(hdr_pool);
          run_crc      = CrcOnes;
          if (payload_left == 0) finish = 1'b1;
          else file_phase = PH_PAYLOAD;
        end
      end
    end else if (file_phase == PH_PAYLOAD) begin
      run_crc      = crc_next(run_crc, b);
      payload_left = payload_left - 1'b1;
      if (payload_left == 0) finish = 1'b1;
    end
    if (finish) begin
      v.crc    = run_crc ^ CrcOnes;
      v.status = (v.crc == hdr_crc) ? ST_OK : ST_MISMATCH;
      emit = 1'b1;
    end
    if (emit) begin
      verdict_out = 1'b1;
      file_phase  = PH_DONE;
    end
    return emit;
  endfunction

  function automatic void check_verdict(input verdict_t want, input verdict_t got);
    if (got.status !== want.status) begin
      $error("status: expected %s, got %0d", want.status.name(), got.status);
      errors++;
    end
    if (got.crc !== want.crc) begin
      $error("computed_crc: expected %08h, got %08h", want.crc, got.crc);
      errors++;
    end
  endfunction

  initial open_file();

  // Predict on every accepted input item.
  always @(posedge clk_i) begin
    verdict_t v;
    if (rst_ni && in_if.valid && in_if.ready) begin
      items_taken++;
      if (judge_item(in_if.op, in_if.data_byte, v)) pending_verdicts.push_back(v);
    end
  end

  // Track register writes.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_if.valid && cfg_if.ready) begin
      case (cfg_index_e'(cfg_if.index))
        CFG_INDEX_CRC:   lim_idx_crc  = cfg_if.data;
        CFG_MAX_RECORDS: lim_max_rec  = cfg_if.data[MaxRecW-1:0];
        CFG_MAX_POOL:    lim_max_pool = cfg_if.data[MaxPoolW-1:0];
        default: ;
      endcase
    end
  end

  // Compare each accepted verdict with the oldest prediction.
  always @(posedge clk_i) begin
    verdict_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got.status = status_e'(out_if.status);
      got.crc    = out_if.computed_crc;
      verdicts_seen++;
      last_verdict = got;
      if (pending_verdicts.size() == 0) begin
        $error("unexpected verdict: status %0d computed_crc %08h", got.status, got.crc);
        errors++;
      end else begin
        check_verdict(pending_verdicts.pop_front(), got);
      end
    end
  end

  // Stop the run when no channel moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result receiver: random stall bursts, one long hold-off on request.
  initial begin
    int n;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_len != 0) begin
        n = hold_len;
        hold_len = 0;
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // Offer one item, with an occasional idle burst before it.
  task automatic send_item(input logic op, input logic [7:0] b);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.op        <= op;
    in_if.data_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  // Stop sending and wait until every predicted verdict has arrived.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write all three registers back to back.
  task automatic program_regs(input logic [31:0] idx_crc, input logic [20:0] mrec,
                              input logic [25:0] mpool);
    cfg_index_e  idx [3];
    logic [31:0] val [3];
    idx = '{CFG_INDEX_CRC, CFG_MAX_RECORDS, CFG_MAX_POOL};
    val = '{idx_crc, {11'd0, mrec}, {6'd0, mpool}};
    set_idx_crc  = idx_crc;
    set_max_rec  = mrec;
    set_max_pool = mpool;
    cfg_if.valid <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Build a file from its description and stream it.
  task automatic send_file(input file_case_t fc);
    logic [7:0]      stream[$];
    logic [7:0]      body[$];
    logic [31:0]     crc;
    logic [31:0]     idx_crc;
    longint unsigned plen;
    longint unsigned nbody;
    int              n;
    plen  = 64'(fc.rec) * RecLen + 64'(fc.pool);
    nbody = plen;
    if (fc.cut >= 0 && fc.cut < 36 + plen) nbody = (fc.cut > 36) ? fc.cut - 36 : 0;
    // A header over the limits is refused, so its payload is left out.
    if (fc.rec > {11'd0, set_max_rec} || fc.pool > {6'd0, set_max_pool}) nbody = 0;
    crc = CrcOnes;
    for (longint unsigned i = 0; i < nbody; i++) begin
      body.push_back(8'($urandom_range(0, 255)));
      crc = crc_next(crc, body[$]);
    end
    crc ^= CrcOnes;
    if (!fc.crc_good) crc ^= 32'd1 << $urandom_range(0, 31);
    idx_crc = (fc.pause_at == 0) ? fc.p_idx : set_idx_crc;

    // Little-endian header.
    for (int i = 0; i < 7; i++) stream.push_back(MagicTag[8*(6-i) +: 8]);
    stream.push_back(8'($urandom_range(0, 255)));
    stream.push_back(8'd1);
    stream.push_back(8'd0);
    stream.push_back(8'(HdrLen));
    stream.push_back(8'd0);
    stream.push_back(8'(RecLen));
    stream.push_back(8'd0);
    stream.push_back(8'($urandom_range(0, 255)));
    stream.push_back(8'($urandom_range(0, 255)));
    for (int i = 0; i < 4; i++) stream.push_back(fc.rec[8*i +: 8]);
    for (int i = 0; i < 4; i++) stream.push_back(fc.pool[8*i +: 8]);
    for (int i = 0; i < 4; i++) stream.push_back(crc[8*i +: 8]);
    for (int i = 0; i < 4; i++) stream.push_back(idx_crc[8*i +: 8]);
    stream.push_back(8'd1);
    repeat (3) stream.push_back(8'd0);
    if (fc.bad_pos >= 0) stream[fc.bad_pos] ^= fc.bad_xor;
    foreach (body[i]) stream.push_back(body[i]);

    n = stream.size();
    if (fc.cut >= 0 && fc.cut < n) begin
      n = fc.cut;
    end else begin
      repeat (fc.trail) stream.push_back(8'($urandom_range(0, 255)));
      n = stream.size();
    end

    for (int i = 0; i <= n; i++) begin
      if (i == fc.pause_at) begin
        drain();
        program_regs(fc.p_idx, fc.p_rec, fc.p_pool);
      end
      if (i < n) send_item(OP_BYTE, stream[i]);
    end
    if (fc.eof) send_item(OP_EOF, 8'($urandom_range(0, 255)));
  endtask

  initial begin
    file_case_t  fc;
    verdict_t    want;
    int          n0;
    int          base;
    int          nfiles;
    int          k;
    int unsigned plen;
    logic [31:0] pick_idx;
    logic [20:0] pick_rec;
    logic [25:0] pick_pool;

    in_if.valid     <= 1'b0;
    in_if.op        <= OP_BYTE;
    in_if.data_byte <= 8'd0;
    cfg_if.valid    <= 1'b0;
    cfg_if.index    <= CFG_INDEX_CRC;
    cfg_if.data     <= 32'd0;
    rst_ni          <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed files, each followed by a full drain.
    foreach (dir_cases[i]) begin
      n0 = verdicts_seen;
      send_file(dir_cases[i]);
      drain();
      if (dir_cases[i].chk) begin
        if (verdicts_seen != n0 + 1) begin
          $error("directed file %0d: expected one verdict, got %0d", i, verdicts_seen - n0);
          errors++;
        end else begin
          want.status = dir_cases[i].st;
          want.crc    = dir_cases[i].crc;
          check_verdict(want, last_verdict);
        end
      end
    end

    // Random files, mostly well formed, with a new register setting every few files.
    base   = items_taken;
    nfiles = 0;
    while (items_taken - base < RandItems) begin
      if (items_taken - base > RandItems * 5 / 6) calm = 1'b1;
      if (nfiles % 7 == 0) begin
        case ((nfiles / 7) % 4)
          0: begin
            pick_idx  = $urandom;
            pick_rec  = 21'd1048576;
            pick_pool = 26'd33554432;
          end
          1: begin
            pick_idx  = 32'd0;
            pick_rec  = 21'd0;
            pick_pool = 26'd0;
          end
          2: begin
            pick_idx  = 32'hFFFF_FFFF;
            pick_rec  = 21'd1;
            pick_pool = 26'd24;
          end
          default: begin
            pick_idx  = $urandom;
            pick_rec  = 21'($urandom_range(0, 3));
            pick_pool = 26'($urandom_range(0, 40));
          end
        endcase
        drain();
        program_regs(pick_idx, pick_rec, pick_pool);
      end
      // Long receiver hold-off while files keep coming.
      if (nfiles == 1) hold_len = HoldCycles;

      fc          = '0;
      fc.bad_pos  = NA;
      fc.cut      = NA;
      fc.pause_at = NA;
      fc.crc_good = ($urandom_range(0, 99) < 85);
      fc.rec      = (set_max_rec != 0 && $urandom_range(0, 3) == 0) ? 32'd1 : 32'd0;
      fc.pool     = $urandom_range(0, (set_max_pool < 24) ? set_max_pool : 24);
      k = $urandom_range(0, 99);
      if (k < 5) begin
        fc.rec = set_max_rec + 1;
      end else if (k < 10) begin
        fc.pool = set_max_pool + 1;
      end else begin
        if (k < 22) begin
          fc.bad_pos = $urandom_range(0, 35);
          fc.bad_xor = 8'($urandom_range(1, 255));
        end
        plen = fc.rec * RecLen + fc.pool;
        k = $urandom_range(0, 99);
        if (k < 8) fc.cut = $urandom_range(0, 35);
        else if (k < 16 && plen > 0) fc.cut = 36 + $urandom_range(0, plen - 1);
      end
      fc.trail = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
      fc.eof   = ($urandom_range(0, 29) != 0);
      send_file(fc);
      nfiles++;
    end

    // Close any open file, then let the last verdicts arrive.
    calm = 1'b1;
    send_item(OP_EOF, 8'($urandom_range(0, 255)));
    drain();
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/mhcv_pkg.sv
design/mhcv_if.sv
design/mhcv_hdr_check.sv
design/manifest_header_crc_validator.sv
sim/tb.sv
